### rtl/text_byte_decoder_assert.svh
// Assertion macros for the text byte decoder
`ifndef TEXT_BYTE_DECODER_ASSERT_SVH
`define TEXT_BYTE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Types, codes and code page tables of the text byte decoder.
// ----------------------------------------------------------------------------
package tbd_pkg;
    localparam int COUNT_WIDTH = 32;
    localparam int MAX_RES     = 5;

    localparam logic [1:0] KIND_CP   = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] EC_NONE      = 3'd0;
    localparam logic [2:0] EC_BAD_START = 3'd1;
    localparam logic [2:0] EC_BAD_CONT  = 3'd2;
    localparam logic [2:0] EC_TRUNC     = 3'd3;
    localparam logic [2:0] EC_NOT_ASCII = 3'd4;
    localparam logic [2:0] EC_UNMAPPED  = 3'd5;

    localparam logic [2:0] ENC_UTF8   = 3'd0;
    localparam logic [2:0] ENC_ASCII  = 3'd1;
    localparam logic [2:0] ENC_LATIN1 = 3'd2;
    localparam logic [2:0] ENC_CP1250 = 3'd3;
    localparam logic [2:0] ENC_CP1251 = 3'd4;
    localparam logic [2:0] ENC_CP1252 = 3'd5;

    localparam logic [1:0] EM_STRICT  = 2'd0;
    localparam logic [1:0] EM_ESCAPE  = 2'd1;
    localparam logic [1:0] EM_REPLACE = 2'd2;
    localparam logic [1:0] EM_IGNORE  = 2'd3;

    localparam logic       REG_ENCODING   = 1'b0;
    localparam logic       REG_ERROR_MODE = 1'b1;

    localparam logic [20:0] CP_REPLACE = 21'h00fffd;
    localparam logic [20:0] CP_ESCAPE  = 21'h00dc00;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] code_point;
        logic [2:0]  error_code;
        logic [31:0] error_position;
        logic [31:0] unit_count;
        logic        last_of_run;
    } t_result;

    typedef logic [15:0] t_page [128];

    localparam t_page PAGE_1250 = '{
      16'h20ac, 16'h0, 16'h201a, 16'h0, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h0, 16'h2030, 16'h0160, 16'h2039, 16'h015a, 16'h0164, 16'h017d, 16'h0179,
      16'h0, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
      16'h0, 16'h2122, 16'h0161, 16'h203a, 16'h015b, 16'h0165, 16'h017e, 16'h017a,
      16'h00a0, 16'h02c7, 16'h02d8, 16'h0141, 16'h00a4, 16'h0104, 16'h00a6, 16'h00a7,
      16'h00a8, 16'h00a9, 16'h015e, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h017b,
      16'h00b0, 16'h00b1, 16'h02db, 16'h0142, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
      16'h00b8, 16'h0105, 16'h015f, 16'h00bb, 16'h013d, 16'h02dd, 16'h013e, 16'h017c,
      16'h0154, 16'h00c1, 16'h00c2, 16'h0102, 16'h00c4, 16'h0139, 16'h0106, 16'h00c7,
      16'h010c, 16'h00c9, 16'h0118, 16'h00cb, 16'h011a, 16'h00cd, 16'h00ce, 16'h010e,
      16'h0110, 16'h0143, 16'h0147, 16'h00d3, 16'h00d4, 16'h0150, 16'h00d6, 16'h00d7,
      16'h0158, 16'h016e, 16'h00da, 16'h0170, 16'h00dc, 16'h00dd, 16'h0162, 16'h00df,
      16'h0155, 16'h00e1, 16'h00e2, 16'h0103, 16'h00e4, 16'h013a, 16'h0107, 16'h00e7,
      16'h010d, 16'h00e9, 16'h0119, 16'h00eb, 16'h011b, 16'h00ed, 16'h00ee, 16'h010f,
      16'h0111, 16'h0144, 16'h0148, 16'h00f3, 16'h00f4, 16'h0151, 16'h00f6, 16'h00f7,
      16'h0159, 16'h016f, 16'h00fa, 16'h0171, 16'h00fc, 16'h00fd, 16'h0163, 16'h02d9};

    localparam t_page PAGE_1251 = '{
      16'h0402, 16'h0403, 16'h201a, 16'h0453, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h20ac, 16'h2030, 16'h0409, 16'h2039, 16'h040a, 16'h040c, 16'h040b, 16'h040f,
      16'h0452, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
      16'h0, 16'h2122, 16'h0459, 16'h203a, 16'h045a, 16'h045c, 16'h045b, 16'h045f,
      16'h00a0, 16'h040e, 16'h045e, 16'h0408, 16'h00a4, 16'h0490, 16'h00a6, 16'h00a7,
      16'h0401, 16'h00a9, 16'h0404, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h0407,
      16'h00b0, 16'h00b1, 16'h0406, 16'h0456, 16'h0491, 16'h00b5, 16'h00b6, 16'h00b7,
      16'h0451, 16'h2116, 16'h0454, 16'h00bb, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
      16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
      16'h0418, 16'h0419, 16'h041a, 16'h041b, 16'h041c, 16'h041d, 16'h041e, 16'h041f,
      16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
      16'h0428, 16'h0429, 16'h042a, 16'h042b, 16'h042c, 16'h042d, 16'h042e, 16'h042f,
      16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
      16'h0438, 16'h0439, 16'h043a, 16'h043b, 16'h043c, 16'h043d, 16'h043e, 16'h043f,
      16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
      16'h0448, 16'h0449, 16'h044a, 16'h044b, 16'h044c, 16'h044d, 16'h044e, 16'h044f};

    localparam t_page PAGE_1252 = '{
      16'h20ac, 16'h0, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0, 16'h017d, 16'h0,
      16'h0, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
      16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h0, 16'h017e, 16'h0178,
      16'h00a0, 16'h00a1, 16'h00a2, 16'h00a3, 16'h00a4, 16'h00a5, 16'h00a6, 16'h00a7,
      16'h00a8, 16'h00a9, 16'h00aa, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h00af,
      16'h00b0, 16'h00b1, 16'h00b2, 16'h00b3, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
      16'h00b8, 16'h00b9, 16'h00ba, 16'h00bb, 16'h00bc, 16'h00bd, 16'h00be, 16'h00bf,
      16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h00c4, 16'h00c5, 16'h00c6, 16'h00c7,
      16'h00c8, 16'h00c9, 16'h00ca, 16'h00cb, 16'h00cc, 16'h00cd, 16'h00ce, 16'h00cf,
      16'h00d0, 16'h00d1, 16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h00d6, 16'h00d7,
      16'h00d8, 16'h00d9, 16'h00da, 16'h00db, 16'h00dc, 16'h00dd, 16'h00de, 16'h00df,
      16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h00e4, 16'h00e5, 16'h00e6, 16'h00e7,
      16'h00e8, 16'h00e9, 16'h00ea, 16'h00eb, 16'h00ec, 16'h00ed, 16'h00ee, 16'h00ef,
      16'h00f0, 16'h00f1, 16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h00f6, 16'h00f7,
      16'h00f8, 16'h00f9, 16'h00fa, 16'h00fb, 16'h00fc, 16'h00fd, 16'h00fe, 16'h00ff};
endpackage

### rtl/text_byte_decoder.sv
// ----------------------------------------------------------------------------
// text_byte_decoder
// Streaming UTF-8 / ASCII / Latin-1 / cp125x byte decoder with error modes.
// ----------------------------------------------------------------------------
// Latency: a byte's first result is shown the cycle after the byte is taken.
// Throughput: one byte per cycle when it yields at most one result and i_stall is
// low; a byte that yields more (up to five, in error bursts or at message end)
// holds the input while the result queue drains one result per unstalled cycle.
// Reset: synchronous, active low; clears decode state, counters and registers
// to encoding utf-8, mode strict. Pending byte storage is not reset.
module text_byte_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_error_position,
    output logic [31:0] o_unit_count,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data
);
    import tbd_pkg::*;
`include "text_byte_decoder_assert.svh"

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // configuration
    logic [2:0] r_encoding;
    logic [1:0] r_error_mode;

    // decode state
    logic [7:0]  r_pend [3];
    logic [1:0]  r_pcount, n_pcount;
    logic [1:0]  r_need, n_need;
    logic [20:0] r_partial, n_partial;
    logic [7:0]  r_lo, n_lo, r_hi, n_hi;
    logic [COUNT_WIDTH-1:0] r_bidx, n_bidx, r_units, n_units;
    logic        r_halted, n_halted;
    logic        pend_wr0, pend_wr;
    logic [1:0]  pend_wr_at;

    // result queue: up to five results per byte, drained one per cycle unless stalled
    t_result     r_q [MAX_RES];
    logic [2:0]  r_qn, r_qhead;
    t_result     n_q [MAX_RES];
    logic [2:0]  n_qn;

    logic accept, out_take, busy;

    assign o_cfg_ready = 1'b1;
    // busy while more than the head result is still to go, or a result waits under i_stall
    assign busy    = (r_qn > r_qhead + 3'd1) || (r_qn != 3'd0 && r_qhead < r_qn && i_stall);
    assign o_stall = busy;
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_qhead < r_qn);
    assign out_take = o_valid && !i_stall;

    always_comb begin
        o_kind           = r_q[r_qhead].kind;
        o_code_point     = r_q[r_qhead].code_point;
        o_error_code     = r_q[r_qhead].error_code;
        o_error_position = r_q[r_qhead].error_position;
        o_unit_count     = r_q[r_qhead].unit_count;
        o_last_of_run    = r_q[r_qhead].last_of_run;
    end

    // ---- combinational decode of one byte ----
    logic [7:0]  b;
    logic [15:0] t;
    logic [2:0]  cnt;
    logic [COUNT_WIDTH-1:0] units;
    logic        halt_v;
    logic [31:0] pos_sat;

    function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hffff_ffff) ? 32'hffff_ffff : w[31:0];
    endfunction

    always_comb begin
        t_result     e;
        logic        bad;
        logic [2:0]  bad_ec;
        logic        restart;
        b        = i_data_byte;
        t        = 16'h0;
        cnt      = 3'd0;
        units    = r_units;
        halt_v   = r_halted;
        n_pcount = r_pcount;
        n_need   = r_need;
        n_partial = r_partial;
        n_lo     = r_lo;
        n_hi     = r_hi;
        pend_wr0 = 1'b0;
        pend_wr  = 1'b0;
        pend_wr_at = 2'd0;
        bad      = 1'b0;
        bad_ec   = EC_NONE;
        restart  = 1'b0;
        pos_sat  = sat32(r_bidx);
        for (int k = 0; k < MAX_RES; k++) begin
            n_q[k] = '0;
        end

        // emit helpers are written inline: append e, bump units on code points
        if (!r_halted) begin
            unique case (r_encoding)
                ENC_LATIN1: begin
                    e = '0; e.code_point = 21'(b);
                    n_q[cnt] = e; cnt = cnt + 3'd1;
                    if (units != CNT_MAX) units = units + 1'b1;
                end
                ENC_ASCII: begin
                    if (!b[7]) begin
                        e = '0; e.code_point = 21'(b);
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        if (units != CNT_MAX) units = units + 1'b1;
                    end else begin
                        bad = 1'b1; bad_ec = EC_NOT_ASCII;
                    end
                end
                ENC_CP1250, ENC_CP1251, ENC_CP1252: begin
                    if (!b[7]) begin
                        e = '0; e.code_point = 21'(b);
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        if (units != CNT_MAX) units = units + 1'b1;
                    end else begin
                        if (r_encoding == ENC_CP1250)      t = PAGE_1250[b[6:0]];
                        else if (r_encoding == ENC_CP1251) t = PAGE_1251[b[6:0]];
                        else                               t = PAGE_1252[b[6:0]];
                        if (t != 16'h0) begin
                            e = '0; e.code_point = 21'(t);
                            n_q[cnt] = e; cnt = cnt + 3'd1;
                            if (units != CNT_MAX) units = units + 1'b1;
                        end else begin
                            bad = 1'b1; bad_ec = EC_UNMAPPED;
                        end
                    end
                end
                default: begin
                    // utf-8 (selectors 6 and 7 too)
                    if (r_pcount == 2'd0 || r_need == 2'd0) begin
                        restart = 1'b1;
                    end else if (b >= r_lo && b <= r_hi) begin
                        n_partial = {r_partial[14:0], b[5:0]};
                        n_need = r_need - 2'd1;
                        n_lo = 8'h80; n_hi = 8'hbf;
                        if (n_need == 2'd0) begin
                            e = '0; e.code_point = n_partial;
                            n_q[cnt] = e; cnt = cnt + 3'd1;
                            if (units != CNT_MAX) units = units + 1'b1;
                            n_pcount = 2'd0; n_partial = '0;
                        end else if (r_pcount != 2'd3) begin
                            pend_wr = 1'b1; pend_wr_at = r_pcount;
                            n_pcount = r_pcount + 2'd1;
                        end
                    end else if (r_error_mode == EM_STRICT) begin
                        e = '0; e.kind = KIND_ERR; e.error_code = EC_BAD_CONT;
                        e.error_position = pos_sat;
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        halt_v = 1'b1;
                        n_pcount = 2'd0; n_need = 2'd0; n_partial = '0;
                        n_lo = 8'h80; n_hi = 8'hbf;
                    end else begin
                        // flush the pending bytes (escaped, replaced or dropped by mode), then restart on this byte
                        if (r_error_mode == EM_ESCAPE) begin
                            for (int i = 0; i < 3; i++) begin
                                if (2'(i) < r_pcount) begin
                                    e = '0; e.code_point = CP_ESCAPE | 21'(r_pend[i]);
                                    n_q[cnt] = e; cnt = cnt + 3'd1;
                                    if (units != CNT_MAX) units = units + 1'b1;
                                end
                            end
                        end else if (r_error_mode == EM_REPLACE) begin
                            e = '0; e.code_point = CP_REPLACE;
                            n_q[cnt] = e; cnt = cnt + 3'd1;
                            if (units != CNT_MAX) units = units + 1'b1;
                        end
                        restart = 1'b1;
                    end
                    if (restart) begin
                        n_pcount = 2'd0; n_need = 2'd0; n_partial = '0;
                        n_lo = 8'h80; n_hi = 8'hbf;
                        if (!b[7]) begin
                            e = '0; e.code_point = 21'(b);
                            n_q[cnt] = e; cnt = cnt + 3'd1;
                            if (units != CNT_MAX) units = units + 1'b1;
                        end else if (b < 8'hc2 || b >= 8'hf5) begin
                            bad = 1'b1; bad_ec = EC_BAD_START;
                        end else begin
                            pend_wr0 = 1'b1;
                            n_pcount = 2'd1;
                            if (b < 8'he0) begin
                                n_need = 2'd1; n_partial = 21'(b[4:0]);
                            end else if (b < 8'hf0) begin
                                n_need = 2'd2; n_partial = 21'(b[3:0]);
                                if (b == 8'he0) n_lo = 8'ha0;
                                else if (b == 8'hed) n_hi = 8'h9f;
                            end else begin
                                n_need = 2'd3; n_partial = 21'(b[2:0]);
                                if (b == 8'hf0) n_lo = 8'h90;
                                else if (b == 8'hf4) n_hi = 8'h8f;
                            end
                        end
                    end
                end
            endcase

            if (bad) begin
                unique case (r_error_mode)
                    EM_STRICT: begin
                        e = '0; e.kind = KIND_ERR; e.error_code = bad_ec;
                        e.error_position = pos_sat;
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        halt_v = 1'b1;
                        n_pcount = 2'd0; n_need = 2'd0; n_partial = '0;
                        n_lo = 8'h80; n_hi = 8'hbf;
                    end
                    EM_ESCAPE: begin
                        e = '0; e.code_point = CP_ESCAPE | 21'(b);
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        if (units != CNT_MAX) units = units + 1'b1;
                    end
                    EM_REPLACE: begin
                        e = '0; e.code_point = CP_REPLACE;
                        n_q[cnt] = e; cnt = cnt + 3'd1;
                        if (units != CNT_MAX) units = units + 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        n_halted = halt_v;
        n_units  = units;
        n_bidx   = r_bidx;

        if (i_end_of_message) begin
            if (!halt_v && n_pcount != 2'd0) begin
                if (r_error_mode == EM_STRICT) begin
                    e = '0; e.kind = KIND_ERR; e.error_code = EC_TRUNC;
                    e.error_position = (r_bidx == CNT_MAX) ? sat32(CNT_MAX)
                        : sat32(r_bidx - COUNT_WIDTH'(n_pcount - 2'd1));
                    n_q[cnt] = e; cnt = cnt + 3'd1;
                end else if (r_error_mode == EM_ESCAPE) begin
                    // pending bytes: the last entry may be the one written this cycle
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < n_pcount) begin
                            e = '0;
                            if (pend_wr0 && i == 0)
                                e.code_point = CP_ESCAPE | 21'(b);
                            else if (pend_wr && 2'(i) == pend_wr_at)
                                e.code_point = CP_ESCAPE | 21'(b);
                            else
                                e.code_point = CP_ESCAPE | 21'(r_pend[i]);
                            n_q[cnt] = e; cnt = cnt + 3'd1;
                            if (units != CNT_MAX) units = units + 1'b1;
                        end
                    end
                end else if (r_error_mode == EM_REPLACE) begin
                    e = '0; e.code_point = CP_REPLACE;
                    n_q[cnt] = e; cnt = cnt + 3'd1;
                    if (units != CNT_MAX) units = units + 1'b1;
                end
            end
            e = '0; e.kind = KIND_DONE; e.unit_count = sat32(units);
            n_q[cnt] = e; cnt = cnt + 3'd1;
            n_pcount = 2'd0; n_need = 2'd0; n_partial = '0;
            n_lo = 8'h80; n_hi = 8'hbf;
            n_bidx = '0; n_units = '0; n_halted = 1'b0;
        end else if (r_bidx != CNT_MAX) begin
            n_bidx = r_bidx + 1'b1;
        end

        if (cnt != 3'd0) n_q[cnt - 3'd1].last_of_run = 1'b1;
        n_qn = cnt;
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding   <= ENC_UTF8;
            r_error_mode <= EM_STRICT;
            r_pcount <= '0; r_need <= '0; r_partial <= '0;
            r_lo <= 8'h80; r_hi <= 8'hbf;
            r_bidx <= '0; r_units <= '0; r_halted <= 1'b0;
            r_qn <= '0; r_qhead <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ENCODING) begin
                    r_encoding <= i_cfg_data;
                    r_pcount <= '0; r_need <= '0; r_partial <= '0;
                    r_lo <= 8'h80; r_hi <= 8'hbf;
                end else begin
                    r_error_mode <= i_cfg_data[1:0];
                end
            end
            if (accept) begin
                r_pcount <= n_pcount; r_need <= n_need; r_partial <= n_partial;
                r_lo <= n_lo; r_hi <= n_hi;
                r_bidx <= n_bidx; r_units <= n_units; r_halted <= n_halted;
                r_qn <= n_qn; r_qhead <= '0;
            end else if (out_take) begin
                r_qhead <= r_qhead + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= n_q;
            if (pend_wr0) r_pend[0] <= i_data_byte;
            if (pend_wr)  r_pend[pend_wr_at] <= i_data_byte;
        end
    end

    `TBD_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_qn <= 3'(MAX_RES))
    `TBD_ASSERT_IMPL(a_head_bound, i_clk, i_rst_n, 1'b1, r_qhead <= r_qn)
    `TBD_ASSERT_IMPL(a_pend_need, i_clk, i_rst_n, r_pcount == 2'd0, r_need == 2'd0)
    `TBD_ASSERT_NEXT(a_eom_clears, i_clk, i_rst_n, accept && i_end_of_message,
        !r_halted && r_bidx == '0)
endmodule
